[rtl/npp_pkg.sv]
// shared constants, types and helpers for the nearest position on polyline block
package npp_pkg;
    localparam int DIM        = 3;
    localparam int CW         = 16;
    localparam int MAXV       = 65536;
    localparam int DW         = 50;
    localparam int TW         = 17;
    localparam int IW         = 16;
    localparam int DLW        = CW + 1;
    localparam int LENW       = 2 * DLW + 2;
    localparam int PRW        = 2 * DLW + 3;
    localparam int EW         = DLW + TW + 2;
    localparam logic [DW-1:0] DSAT = {DW{1'b1}};
    localparam logic [TW-1:0] ONE_Q16 = TW'(65536);
    localparam logic [TW-1:0] HALF_Q16 = TW'(32768);
    localparam int DIVSTEPS = 16;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_DIV, ST_ERR, ST_SQ, ST_CMP, ST_OUT
    } t_state;

    typedef struct packed {
        logic             found;
        logic [IW-1:0]    whole;
        logic [TW-1:0]    frac;
        logic [DW-1:0]    dist_sq;
    } t_result;

    typedef struct packed {
        logic             go;
        logic [TW-1:0]    t;
    } t_lane_ctl;

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DW] ? DSAT : s[DW-1:0];
    endfunction
endpackage

[rtl/npp_if.sv]
// valid/ready channel interface with payload
interface npp_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/npp_lane.sv]
// one coordinate lane: differences, error term and its square in Q16
module npp_lane (
    input  logic                        i_clk,
    input  logic signed [npp_pkg::CW-1:0] i_q,
    input  logic signed [npp_pkg::CW-1:0] i_v0,
    input  logic signed [npp_pkg::CW-1:0] i_v1,
    input  logic                        i_load,
    input  npp_pkg::t_lane_ctl          i_ctl,
    input  logic                        i_sq,
    output logic [2*npp_pkg::DLW+1:0]   o_len,
    output logic signed [npp_pkg::PRW-1:0] o_prod,
    output logic [npp_pkg::DW-1:0]      o_wsq,
    output logic [npp_pkg::DW-1:0]      o_esq
);
    import npp_pkg::*;
    logic signed [DLW-1:0] r_del, r_w;
    logic signed [EW-1:0]  r_e;
    logic [DW-1:0]         r_esq;
    logic [EW-1:0]         mag;
    logic [EW-17:0]        a16;
    logic [15:0]           b16;
    logic [2*(EW-16)-1:0]  sq_hi;
    logic [EW-1:0]         sq_mid;
    logic [31:0]           sq_lo;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_del <= DLW'(i_v1) - DLW'(i_v0);
            r_w   <= DLW'(i_q) - DLW'(i_v0);
        end
        if (i_ctl.go) begin
            r_e <= (EW'(r_w) <<< 16) - EW'($signed({1'b0, i_ctl.t})) * EW'(r_del);
        end
        if (i_sq) begin
            // magnitudes from 2^33 up square past the 50-bit range
            r_esq <= (|mag[EW-1:33]) ? DSAT :
                     (DW'(sq_hi) << 16) + (DW'(sq_mid) << 1) + DW'(sq_lo[31:16]);
        end
    end

    assign mag  = r_e[EW-1] ? EW'(-r_e) : EW'(r_e);
    assign a16  = mag[EW-1:16];
    assign b16  = mag[15:0];
    // square split into high, cross and low partial products
    assign sq_hi  = (2*(EW-16))'(a16) * (2*(EW-16))'(a16);
    assign sq_mid = EW'(a16) * EW'(b16);
    assign sq_lo  = 32'(b16) * 32'(b16);
    assign o_len  = (2*DLW+2)'(r_del * r_del);
    assign o_prod = PRW'(r_w * r_del);
    assign o_wsq  = DW'(r_w * r_w);
    assign o_esq  = r_esq;
endmodule

[rtl/npp_div.sv]
// restoring divider for t = floor(prod * 65536 / len)
module npp_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [npp_pkg::LENW-1:0]  i_num,
    input  logic [npp_pkg::LENW-1:0]  i_den,
    output logic                      o_done,
    output logic [15:0]               o_q
);
    import npp_pkg::*;
    logic [LENW:0]   r_r;
    logic [LENW-1:0] r_d;
    logic [15:0]     r_q;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic [LENW:0]   sh;

    assign sh = {r_r[LENW-1:0], 1'b0};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(DIVSTEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_r <= {1'b0, i_num};
            r_d <= i_den;
            r_q <= '0;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_d}) begin
                r_r <= sh - {1'b0, r_d};
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_r <= sh;
                r_q <= {r_q[14:0], 1'b0};
            end
        end
    end
    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_q    = (sh >= {1'b0, r_d}) ? {r_q[14:0], 1'b1} : {r_q[14:0], 1'b0};
endmodule

[rtl/nearest_position_on_polyline.sv]
// nearest position on polyline: top level with lanes, divider and merge
// usage: vertices enter on i_vtx, one beat per vertex with track id and last flag;
// the query point sits in four configuration registers written by i_cfg_we.
// consecutive vertices of equal track id form a segment; on the last vertex one
// result beat leaves on o_res with found, position and squared distance.
// a vertex without a segment goes from setup straight to output; a zero-length
// segment passes through compare first, and one where t clamps to 0 or 1 also
// through error and square; otherwise the 16-step restoring divider runs for t
// before error and square in the per-coordinate lanes and the compare.
// one vertex is worked on at a time; i_vtx.ready is low while busy or while
// a result waits in the output register.
// a stalled receiver holds the result; the next vertex waits for it to go.
// reset clears the path state and the query registers to zero, but the best distance to saturation.
module nearest_position_on_polyline (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    npp_if.sink                       i_vtx,
    npp_if.source                     o_res,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [npp_pkg::CW-1:0]    i_cfg_data
);
    import npp_pkg::*;

    t_state r_state, n_state;
    logic signed [CW-1:0] r_q [4];
    logic signed [CW-1:0] r_prev [DIM];
    logic signed [CW-1:0] r_cur [DIM];
    logic [IW-1:0] r_ptrack, r_cnt, r_segidx;
    logic r_have, r_last, r_seg;
    logic [DW-1:0] r_bdist, r_dist;
    logic [IW-1:0] r_bwhole;
    logic [TW-1:0] r_bfrac, r_t;
    logic r_bfound, r_ovalid;
    t_result r_res;
    logic [LENW-1:0] r_len;

    logic accept;
    logic [LENW-1:0] lens [DIM];
    logic signed [PRW-1:0] prods [DIM];
    logic [DW-1:0] wsqs [DIM], esqs [DIM];
    logic [LENW-1:0] len_sum;
    logic signed [PRW-1:0] prod_sum;
    logic [DW-1:0] wsq_sum, esq_sum;
    logic div_start, div_done, load, sq_en;
    logic [15:0] div_q;
    t_lane_ctl lctl;

    assign accept = i_vtx.valid && i_vtx.ready;
    assign i_vtx.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign load = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_q[j] <= '0;
        end else if (i_cfg_we) begin
            r_q[i_cfg_idx] <= i_cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIM; g++) begin : g_lane
            npp_lane u_lane (
                .i_clk(i_clk), .i_q(r_q[g]), .i_v0(r_prev[g]),
                .i_v1(i_vtx.data[(g+1)*CW+16:g*CW+17]),
                .i_load(load), .i_ctl(lctl), .i_sq(sq_en),
                .o_len(lens[g]), .o_prod(prods[g]), .o_wsq(wsqs[g]), .o_esq(esqs[g]));
        end
    endgenerate

    always_comb begin
        len_sum = '0; prod_sum = '0; wsq_sum = '0; esq_sum = '0;
        for (int j = 0; j < DIM; j++) begin
            len_sum  = len_sum + LENW'(lens[j]);
            prod_sum = prod_sum + prods[j];
            wsq_sum  = wsq_sum + wsqs[j];
            esq_sum  = sat_add(esq_sum, esqs[j]);
        end
    end

    // the divider loads the lane sums at the edge that leaves setup
    npp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(LENW'(prod_sum)), .i_den(len_sum), .o_done(div_done), .o_q(div_q));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_PREP;
            ST_PREP: begin
                if (!r_seg) n_state = ST_OUT;
                else if (len_sum == '0) n_state = ST_CMP;
                else if (prod_sum <= 0 || LENW'(prod_sum) >= len_sum) n_state = ST_ERR;
                else n_state = ST_DIV;
            end
            ST_DIV:  if (div_done) n_state = ST_ERR;
            ST_ERR:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_CMP;
            ST_CMP:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        lctl.go   = 1'b0;
        lctl.t    = r_t;
        sq_en     = 1'b0;
        case (r_state)
            ST_DIV:  div_start = 1'b0;
            ST_ERR:  lctl.go = 1'b1;
            ST_SQ:   sq_en = 1'b1;
            default: ;
        endcase
        if (r_state == ST_PREP && n_state == ST_DIV) div_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_have <= 1'b0; r_ptrack <= '0; r_cnt <= '0;
            r_bdist <= DSAT; r_bwhole <= '0; r_bfrac <= '0; r_bfound <= 1'b0;
            r_ovalid <= 1'b0;
            for (int j = 0; j < DIM; j++) r_prev[j] <= '0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            if (accept) begin
                r_seg <= r_have && (i_vtx.data[16:1] == r_ptrack);
                r_last <= i_vtx.data[0];
                r_ptrack <= i_vtx.data[16:1];
                r_have <= 1'b1;
                r_segidx <= r_cnt;
                if (r_cnt != IW'(MAXV-1)) r_cnt <= r_cnt + 1'b1;
                for (int j = 0; j < DIM; j++)
                    r_cur[j] <= i_vtx.data[(j+1)*CW+16 -: CW];
            end
            if (r_state == ST_PREP) begin
                for (int j = 0; j < DIM; j++) r_prev[j] <= r_cur[j];
                r_len <= len_sum;
                if (len_sum == '0) begin
                    r_t <= HALF_Q16;
                    r_dist <= (wsq_sum > (DSAT >> 16)) ? DSAT : (wsq_sum << 16);
                end else if (prod_sum <= 0) r_t <= '0;
                else if (LENW'(prod_sum) >= len_sum) r_t <= ONE_Q16;
            end
            if (r_state == ST_DIV && div_done) r_t <= {1'b0, div_q};
            if (r_state == ST_CMP) begin
                logic [DW-1:0] d;
                d = (r_len == '0) ? r_dist : esq_sum;
                if (!r_bfound || d < r_bdist) begin
                    r_bfound <= 1'b1; r_bdist <= d; r_bwhole <= r_segidx; r_bfrac <= r_t;
                end
            end
            if (r_state == ST_OUT && r_last) begin
                r_ovalid <= 1'b1;
                r_res.found   <= r_bfound;
                r_res.whole   <= r_bfound ? r_bwhole : '0;
                r_res.frac    <= r_bfound ? r_bfrac : '0;
                r_res.dist_sq <= r_bfound ? r_bdist : '0;
                r_have <= 1'b0; r_ptrack <= '0; r_cnt <= '0;
                r_bdist <= DSAT; r_bwhole <= '0; r_bfrac <= '0; r_bfound <= 1'b0;
                for (int j = 0; j < DIM; j++) r_prev[j] <= '0;
            end
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    logic unused_q;
    assign unused_q = ^{r_q[3]};

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx.ready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid && $stable(o_res.data))
        else $error("result dropped");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.frac <= ONE_Q16)) else $error("t out of range");
`endif
endmodule

[bench/npp_checker.sv]
// vertex payload type and scoreboard that predicts and checks every result beat
`timescale 1ns / 1ps

package npp_bench_pkg;
    import npp_pkg::*;
    typedef struct packed {
        logic [3:0][CW-1:0] coord;
        logic [IW-1:0]      track_id;
        logic               last_vertex;
    } t_vertex;
endpackage

module npp_checker
    import npp_pkg::*;
    import npp_bench_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vtx_valid,
    input  logic                i_vtx_ready,
    input  t_vertex             i_vtx_data,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  t_result             i_res_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CW-1:0]       i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    localparam longint unsigned DIST_MAX = (64'd1 << 50) - 1;

    logic signed [CW-1:0] query [4];
    longint               last_pt [4];
    logic [IW-1:0]        last_track;
    logic                 have_last;
    longint unsigned      vtx_count;
    longint unsigned      best_dist;
    logic [IW-1:0]        best_whole;
    logic [TW-1:0]        best_frac;
    logic                 best_found;
    t_result              expected_results [$];

    function automatic longint unsigned dist_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > DIST_MAX) ? DIST_MAX : s;
    endfunction

    // floor(m*m / 2^16) with saturation
    function automatic longint unsigned err_square(longint unsigned m);
        longint unsigned a, b;
        if (m >= (64'd1 << 33)) return DIST_MAX;
        a = m >> 16;
        b = m & 64'hFFFF;
        return dist_add((a * a) << 16, 2 * a * b + ((b * b) >> 16));
    endfunction

    task automatic clear_path();
        for (int j = 0; j < 4; j++) last_pt[j] = 0;
        last_track = '0;
        have_last  = 1'b0;
        vtx_count  = 0;
        best_dist  = DIST_MAX;
        best_whole = '0;
        best_frac  = '0;
        best_found = 1'b0;
    endtask

    task automatic project_segment(input longint pt [4]);
        longint          del [4];
        longint          w [4];
        longint          len, dot, e;
        longint unsigned seg_dist, t, s, r, q, m;
        len  = 0;
        dot  = 0;
        seg_dist = 0;
        for (int j = 0; j < DIM; j++) begin
            del[j] = pt[j] - last_pt[j];
            w[j]   = longint'(query[j]) - last_pt[j];
            len   += del[j] * del[j];
            dot   += w[j] * del[j];
        end
        if (len == 0) begin
            // degenerate segment: distance to its start point
            s = 0;
            for (int j = 0; j < DIM; j++) s += w[j] * w[j];
            seg_dist = (s > (DIST_MAX >> 16)) ? DIST_MAX : (s << 16);
            t = 32768;
        end else begin
            if (dot <= 0) t = 0;
            else if (dot >= len) t = 65536;
            else begin
                r = dot;
                q = 0;
                for (int k = 0; k < DIVSTEPS; k++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= len) begin
                        r = r - len;
                        q = q | 1;
                    end
                end
                t = q;
            end
            for (int j = 0; j < DIM; j++) begin
                e = w[j] * 65536 - longint'(t) * del[j];
                m = (e < 0) ? -e : e;
                seg_dist = dist_add(seg_dist, err_square(m));
            end
        end
        if (!best_found || seg_dist < best_dist) begin
            best_found = 1'b1;
            best_dist  = seg_dist;
            best_whole = vtx_count[IW-1:0];
            best_frac  = t[TW-1:0];
        end
    endtask

    task automatic take_vertex(input t_vertex v);
        longint  pt [4];
        t_result res;
        for (int j = 0; j < 4; j++) pt[j] = longint'($signed(v.coord[j]));
        if (have_last && v.track_id == last_track) project_segment(pt);
        for (int j = 0; j < 4; j++) last_pt[j] = pt[j];
        last_track = v.track_id;
        have_last  = 1'b1;
        if (vtx_count < MAXV - 1) vtx_count++;
        if (v.last_vertex) begin
            if (best_found) begin
                res.found   = 1'b1;
                res.whole   = best_whole;
                res.frac    = best_frac;
                res.dist_sq = best_dist[DW-1:0];
            end else begin
                res = '0;
            end
            expected_results.push_back(res);
            clear_path();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) query[j] <= '0;
            clear_path();
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) query[i_cfg_idx] <= i_cfg_data;
            if (i_vtx_valid && i_vtx_ready) take_vertex(i_vtx_data);
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("%0t unexpected result beat %p", $realtime, i_res_data);
                end else begin
                    want = expected_results.pop_front();
                    if (want.found !== i_res_data.found || want.whole !== i_res_data.whole ||
                        want.frac !== i_res_data.frac ||
                        want.dist_sq !== i_res_data.dist_sq) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("%0t mismatch: expected %p got %p",
                                     $realtime, want, i_res_data);
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

[bench/testbench.sv]
// stimulus, clock, reset and verdict for the nearest position on polyline block
`timescale 1ns / 1ps

module testbench;
    import npp_pkg::*;
    import npp_bench_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_idx = '0;
    logic [CW-1:0] cfg_data = '0;
    logic          calm = 1'b0;
    int            errors, pending, quiet_cycles, stall_left;
    logic [IW-1:0] track;

    npp_if #(.T(t_vertex)) vtx_ch ();
    npp_if #(.T(t_result)) res_ch ();

    always #4 i_clk = ~i_clk;

    nearest_position_on_polyline i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (vtx_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    npp_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx_valid (vtx_ch.valid),
        .i_vtx_ready (vtx_ch.ready),
        .i_vtx_data  (vtx_ch.data),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res_data  (res_ch.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        vtx_ch.valid = 1'b0;
        vtx_ch.data  = '0;
        res_ch.ready = 1'b0;
        stall_left   = 0;
    end

    // receiver stalls in short bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_vertex(input logic [CW-1:0] c0, c1, c2, c3,
                               input logic [IW-1:0] id, input logic last);
        t_vertex v;
        v.coord       = {c3, c2, c1, c0};
        v.track_id    = id;
        v.last_vertex = last;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            vtx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        vtx_ch.valid <= 1'b1;
        vtx_ch.data  <= v;
        do @(posedge i_clk); while (!vtx_ch.ready);
    endtask

    task automatic write_query(input logic [CW-1:0] q0, q1, q2, q3);
        logic [CW-1:0] vals [4];
        vals = '{q0, q1, q2, q3};
        @(negedge i_clk);
        vtx_ch.valid <= 1'b0;
        wait (pending == 0);
        // results never come from a vertex without last, so let the block drain
        repeat (40) @(negedge i_clk);
        for (int j = 0; j < 4; j++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= j[1:0];
            cfg_data <= vals[j];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return CW'($urandom);
            1: return CW'(int'($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return CW'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // random paths: mostly one track, some track switches and lone vertices
    task automatic random_paths(input int count);
        int            sent, len;
        logic [CW-1:0] c0, c1, c2;
        sent = 0;
        while (sent < count) begin
            len   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
            track = IW'($urandom);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) track = IW'($urandom);
                if (k > 0 && $urandom_range(0, 9) == 0) begin
                    // repeat the previous point for a zero-length segment
                    send_vertex(c0, c1, c2, CW'($urandom), track, k == len - 1);
                end else begin
                    c0 = pick_coord();
                    c1 = pick_coord();
                    c2 = pick_coord();
                    send_vertex(c0, c1, c2, CW'($urandom), track, k == len - 1);
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: query at origin after reset
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        send_vertex(16'd5, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
        send_vertex(16'd3, 16'd4, 16'd0, 16'd0, 16'h1234, 1'b0);
        send_vertex(16'd3, 16'd4, 16'd0, 16'd0, 16'h1234, 1'b1);
        send_vertex(16'd10, 16'd1, 16'd0, 16'd0, 16'hAAAA, 1'b0);
        send_vertex(16'd20, 16'd1, 16'd0, 16'd0, 16'hAAAA, 1'b0);
        send_vertex(-16'sd10, 16'd1, 16'd0, 16'd0, 16'h5555, 1'b0);
        send_vertex(16'd10, 16'd1, 16'd0, 16'd0, 16'h5555, 1'b0);
        send_vertex(16'd10, 16'd1, 16'd0, 16'd0, 16'h5555, 1'b0);
        send_vertex(-16'sd10, 16'd1, 16'd0, 16'd0, 16'h5555, 1'b1);
        send_vertex(16'd1, 16'd0, 16'd0, 16'd0, 16'h0001, 1'b0);
        send_vertex(16'd1, 16'd0, 16'd0, 16'd0, 16'h0002, 1'b0);
        send_vertex(16'd3, 16'd0, 16'd0, 16'd0, 16'h0002, 1'b1);

        write_query(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0007, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0007, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0007, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0007, 1'b1);
        random_paths(100);

        write_query(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        random_paths(100);
        write_query(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_paths(100);
        write_query(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        random_paths(100);
        write_query(CW'($urandom_range(0, 40)), 16'hFFF0, CW'($urandom), CW'($urandom));
        random_paths(100);
        calm = 1'b1;
        random_paths(100);

        @(negedge i_clk);
        vtx_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
